// ===== rtl/transposed_slab_copy_address_gen_defines.svh =====
// Assertion macros used by the top-level file.
`ifndef TRANSPOSED_SLAB_COPY_ADDRESS_GEN_DEFINES_SVH
`define TRANSPOSED_SLAB_COPY_ADDRESS_GEN_DEFINES_SVH

// Same-cycle implication.
`define TSC_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// Next-cycle implication.
`define TSC_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

// ===== rtl/tsc_pkg.sv =====
package tsc_pkg;

    localparam int MAX_DIMS   = 4;
    localparam int DIM_WIDTH  = 16;
    localparam int LEVEL_W    = $clog2(MAX_DIMS);
    localparam int DATA_W     = 64;
    localparam int OFFSET_W   = 32;
    localparam int STATUS_W   = 2;

    localparam int CFG_DATA_W = 64;
    localparam int CFG_ADDR_W = 6;
    localparam int REG_LSB    = 3;
    localparam int REG_IDX_W  = CFG_ADDR_W - REG_LSB;

    localparam int RANK_W     = 3;
    localparam int ORDER_W    = MAX_DIMS * LEVEL_W;
    localparam int EB_W       = 4;
    localparam int EB_MAX     = 8;

    localparam logic [REG_IDX_W-1:0] REG_RANK         = 3'd0;
    localparam logic [REG_IDX_W-1:0] REG_DIM_ORDER    = 3'd1;
    localparam logic [REG_IDX_W-1:0] REG_DEST_SIZES   = 3'd2;
    localparam logic [REG_IDX_W-1:0] REG_SLAB_SIZES   = 3'd3;
    localparam logic [REG_IDX_W-1:0] REG_SLAB_OFFSETS = 3'd4;
    localparam logic [REG_IDX_W-1:0] REG_ELEM_BYTES   = 3'd5;

    localparam logic [STATUS_W-1:0] STATUS_OK        = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_MISFIT    = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_TOO_LARGE = 2'd2;

    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    typedef logic [DIM_WIDTH-1:0] dim_t;

    typedef struct packed {
        logic [DATA_W-1:0]  data;
        logic               last;
        logic [LEVEL_W-1:0] level;
    } item_t;

    typedef struct packed {
        logic busy;
        logic restart;
    } setup_ctl_t;

endpackage

// ===== rtl/tsc_setup.sv =====
module tsc_setup import tsc_pkg::*; #(
    parameter int ADDR_WIDTH = 32
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  psel,
    input  logic                                  penable,
    input  logic                                  pwrite,
    input  logic [CFG_ADDR_W-1:0]                 paddr,
    input  logic [CFG_DATA_W-1:0]                 pwdata,
    output logic [CFG_DATA_W-1:0]                 prdata,
    output setup_ctl_t                            ctl,
    output dim_t [MAX_DIMS-1:0]                   len_m1,
    output logic [MAX_DIMS-1:0][ADDR_WIDTH-1:0]   strides,
    output logic [ADDR_WIDTH-1:0]                 start_addr,
    output logic [STATUS_W-1:0]                   cfg_status
);

    localparam int STEP_W  = $clog2(MAX_DIMS + 3);
    localparam logic [STEP_W-1:0] STEP_LOAD  = STEP_W'(0);
    localparam logic [STEP_W-1:0] STEP_FLUSH = STEP_W'(MAX_DIMS + 1);
    localparam logic [STEP_W-1:0] STEP_DONE  = STEP_W'(MAX_DIMS + 2);
    localparam int PROD_W  = ADDR_WIDTH + DIM_WIDTH;
    localparam int TOTAL_W = ADDR_WIDTH + 1;
    localparam int TPROD_W = TOTAL_W + DIM_WIDTH;
    localparam logic [TPROD_W-1:0] LIMIT = {{DIM_WIDTH{1'b0}}, 1'b1, {ADDR_WIDTH{1'b0}}};

    logic [RANK_W-1:0]            rank_reg;
    logic [ORDER_W-1:0]           order_reg;
    logic [CFG_DATA_W-1:0]        dest_sizes_reg;
    logic [CFG_DATA_W-1:0]        slab_sizes_reg;
    logic [CFG_DATA_W-1:0]        slab_offsets_reg;
    logic [EB_W-1:0]              eb_reg;

    logic                         busy_reg;
    logic [STEP_W-1:0]            step_reg;
    logic                         toolarge_reg;
    logic [STATUS_W-1:0]          status_reg;

    logic [ADDR_WIDTH-1:0]        stride_reg;
    logic [TOTAL_W-1:0]           total_reg;
    logic [ADDR_WIDTH-1:0]        term_reg;
    logic [ADDR_WIDTH-1:0]        start_reg;
    logic [ADDR_WIDTH-1:0]        strides_reg [MAX_DIMS];

    logic                         wr_en;
    logic                         wr_hit;
    logic [REG_IDX_W-1:0]         wr_idx;
    logic [RANK_W-1:0]            rank_eff;
    logic [EB_W-1:0]              eb_eff;
    logic [MAX_DIMS-1:0]          in_rank;
    dim_t                         slab_len [MAX_DIMS];
    dim_t                         offs [MAX_DIMS];
    dim_t                         dlen [MAX_DIMS];
    logic [LEVEL_W-1:0]           dsel [MAX_DIMS];
    logic                         misfit;

    logic                         dim_step;
    logic [LEVEL_W-1:0]           dim_idx;
    dim_t                         dlen_cur;
    logic [LEVEL_W-1:0]           dsel_cur;
    dim_t                         off_cur;
    logic [PROD_W-1:0]            stride_prod;
    logic [PROD_W-1:0]            term_prod;
    logic [TPROD_W-1:0]           total_prod;
    logic                         toolarge_next;
    logic [TOTAL_W-1:0]           total_next;
    logic [ADDR_WIDTH-1:0]        stride_next;

    assign wr_en  = psel && penable && pwrite;
    assign wr_idx = paddr[CFG_ADDR_W-1:REG_LSB];
    assign wr_hit = wr_en && (wr_idx <= REG_ELEM_BYTES);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rank_reg         <= RANK_W'(1);
            order_reg        <= ORDER_W'(228);
            dest_sizes_reg   <= 64'h0001_0001_0001_0001;
            slab_sizes_reg   <= 64'h0001_0001_0001_0001;
            slab_offsets_reg <= '0;
            eb_reg           <= EB_W'(4);
        end
        else if (wr_en)
        begin
            unique case (wr_idx)
                REG_RANK:         rank_reg         <= pwdata[RANK_W-1:0];
                REG_DIM_ORDER:    order_reg        <= pwdata[ORDER_W-1:0];
                REG_DEST_SIZES:   dest_sizes_reg   <= pwdata;
                REG_SLAB_SIZES:   slab_sizes_reg   <= pwdata;
                REG_SLAB_OFFSETS: slab_offsets_reg <= pwdata;
                REG_ELEM_BYTES:   eb_reg           <= pwdata[EB_W-1:0];
                default:          ;
            endcase
        end
    end

    always_comb
    begin
        unique case (paddr[CFG_ADDR_W-1:REG_LSB])
            REG_RANK:         prdata = CFG_DATA_W'(rank_reg);
            REG_DIM_ORDER:    prdata = CFG_DATA_W'(order_reg);
            REG_DEST_SIZES:   prdata = dest_sizes_reg;
            REG_SLAB_SIZES:   prdata = slab_sizes_reg;
            REG_SLAB_OFFSETS: prdata = slab_offsets_reg;
            REG_ELEM_BYTES:   prdata = CFG_DATA_W'(eb_reg);
            default:          prdata = '0;
        endcase
    end

    // Clamp and unpack the configuration and flag a slab that does not fit its destination.
    always_comb
    begin
        rank_eff = (rank_reg > RANK_W'(MAX_DIMS)) ? RANK_W'(MAX_DIMS) : rank_reg;
        eb_eff   = (eb_reg == '0) ? EB_W'(1) :
                   ((eb_reg > EB_W'(EB_MAX)) ? EB_W'(EB_MAX) : eb_reg);
        for (int n = 0; n < MAX_DIMS; n++)
        begin
            in_rank[n]  = RANK_W'(n) < rank_eff;
            slab_len[n] = (!in_rank[n] || slab_sizes_reg[n*DIM_WIDTH +: DIM_WIDTH] == '0)
                          ? dim_t'(1) : slab_sizes_reg[n*DIM_WIDTH +: DIM_WIDTH];
            offs[n]     = in_rank[n] ? slab_offsets_reg[n*DIM_WIDTH +: DIM_WIDTH] : '0;
            dlen[n]     = in_rank[n] ? dest_sizes_reg[n*DIM_WIDTH +: DIM_WIDTH] : dim_t'(1);
            dsel[n]     = in_rank[n] ? order_reg[n*LEVEL_W +: LEVEL_W] : LEVEL_W'(n);
            len_m1[n]   = slab_len[n] - dim_t'(1);
        end
        misfit = 1'b0;
        for (int n = 0; n < MAX_DIMS; n++)
        begin
            if (in_rank[n] && (({1'b0, offs[dsel[n]]} + {1'b0, slab_len[dsel[n]]})
                               > {1'b0, dlen[n]}))
            begin
                misfit = 1'b1;
            end
        end
    end

    assign dim_step    = (step_reg != STEP_LOAD) && (step_reg < STEP_FLUSH);
    assign dim_idx     = LEVEL_W'(step_reg - STEP_W'(1));
    assign dlen_cur    = dlen[dim_idx];
    assign dsel_cur    = dsel[dim_idx];
    assign off_cur     = offs[dsel_cur];
    assign stride_prod = PROD_W'(stride_reg) * PROD_W'(dlen_cur);
    assign term_prod   = PROD_W'(stride_reg) * PROD_W'(off_cur);
    assign total_prod  = TPROD_W'(total_reg) * TPROD_W'(dlen_cur);
    assign stride_next = stride_prod[ADDR_WIDTH-1:0];

    always_comb
    begin
        toolarge_next = toolarge_reg || ((dlen_cur != '0) && (total_prod > LIMIT));
        if (dlen_cur == '0)
        begin
            total_next = '0;
        end
        else if (toolarge_next)
        begin
            total_next = total_reg;
        end
        else
        begin
            total_next = total_prod[TOTAL_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg     <= 1'b1;
            step_reg     <= STEP_LOAD;
            toolarge_reg <= 1'b0;
            status_reg   <= STATUS_OK;
        end
        else if (wr_hit)
        begin
            busy_reg <= 1'b1;
            step_reg <= STEP_LOAD;
        end
        else if (busy_reg)
        begin
            if (step_reg == STEP_DONE)
            begin
                busy_reg   <= 1'b0;
                status_reg <= misfit ? STATUS_MISFIT :
                              (toolarge_reg ? STATUS_TOO_LARGE : STATUS_OK);
            end
            else
            begin
                step_reg <= step_reg + STEP_W'(1);
            end
            if (step_reg == STEP_LOAD)
            begin
                toolarge_reg <= 1'b0;
            end
            else if (dim_step)
            begin
                toolarge_reg <= toolarge_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (step_reg == STEP_LOAD)
        begin
            stride_reg <= ADDR_WIDTH'(eb_eff);
            total_reg  <= TOTAL_W'(eb_eff);
            term_reg   <= '0;
            start_reg  <= '0;
            for (int s = 0; s < MAX_DIMS; s++)
            begin
                strides_reg[s] <= '0;
            end
        end
        else if (step_reg != STEP_DONE)
        begin
            start_reg <= start_reg + term_reg;
            if (dim_step)
            begin
                stride_reg <= stride_next;
                total_reg  <= total_next;
                term_reg   <= term_prod[ADDR_WIDTH-1:0];
                for (int s = 0; s < MAX_DIMS; s++)
                begin
                    if (LEVEL_W'(s) == dsel_cur)
                    begin
                        strides_reg[s] <= strides_reg[s] + stride_reg;
                    end
                end
            end
        end
    end

    always_comb
    begin
        for (int s = 0; s < MAX_DIMS; s++)
        begin
            strides[s] = strides_reg[s];
        end
    end

    assign start_addr  = start_reg;
    assign cfg_status  = status_reg;
    assign ctl.busy    = busy_reg;
    assign ctl.restart = busy_reg && (step_reg == STEP_DONE);

endmodule

// ===== rtl/tsc_front.sv =====
module tsc_front import tsc_pkg::*; (
    input  logic                 clk,
    input  logic                 rst_n,
    input  setup_ctl_t           ctl,
    input  dim_t [MAX_DIMS-1:0]  len_m1,
    input  logic                 in_valid,
    output logic                 in_stall,
    input  logic [DATA_W-1:0]    elem_data,
    input  logic                 q_full,
    output logic                 q_push,
    output item_t                q_item
);

    dim_t                 cnt_reg [MAX_DIMS];
    logic [MAX_DIMS-1:0]  at_end;
    logic                 is_last;
    logic [LEVEL_W-1:0]   level;

    always_comb
    begin
        level = '0;
        for (int s = 0; s < MAX_DIMS; s++)
        begin
            at_end[s] = cnt_reg[s] == len_m1[s];
        end
        for (int s = MAX_DIMS - 1; s >= 0; s--)
        begin
            if (!at_end[s])
            begin
                level = LEVEL_W'(s);
            end
        end
        is_last = &at_end;
    end

    assign in_stall     = ctl.busy || q_full;
    assign q_push       = in_valid && !in_stall;
    assign q_item.data  = elem_data;
    assign q_item.last  = is_last;
    assign q_item.level = level;

    // Advance the source counters; the lowest dimension not at its end carries.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int s = 0; s < MAX_DIMS; s++)
            begin
                cnt_reg[s] <= '0;
            end
        end
        else if (ctl.restart)
        begin
            for (int s = 0; s < MAX_DIMS; s++)
            begin
                cnt_reg[s] <= '0;
            end
        end
        else if (q_push)
        begin
            for (int s = 0; s < MAX_DIMS; s++)
            begin
                if (is_last || (LEVEL_W'(s) < level))
                begin
                    cnt_reg[s] <= '0;
                end
                else if (LEVEL_W'(s) == level)
                begin
                    cnt_reg[s] <= cnt_reg[s] + dim_t'(1);
                end
            end
        end
    end

endmodule

// ===== rtl/tsc_queue.sv =====
module tsc_queue import tsc_pkg::*; (
    input  logic   clk,
    input  logic   rst_n,
    input  logic   push,
    input  item_t  push_item,
    input  logic   pop,
    output item_t  head,
    output logic   full,
    output logic   avail
);

    item_t               mem_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0]   wr_ptr_reg;
    logic [QPTR_W-1:0]   rd_ptr_reg;
    logic [QCNT_W-1:0]   count_reg;

    assign full  = count_reg == QCNT_W'(QUEUE_DEPTH);
    assign avail = count_reg != '0;
    assign head  = mem_reg[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= push_item;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + QPTR_W'(1);
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + QPTR_W'(1);
            end
            if (push && !pop)
            begin
                count_reg <= count_reg + QCNT_W'(1);
            end
            else if (pop && !push)
            begin
                count_reg <= count_reg - QCNT_W'(1);
            end
        end
    end

endmodule

// ===== rtl/tsc_back.sv =====
module tsc_back import tsc_pkg::*; #(
    parameter int ADDR_WIDTH = 32
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  setup_ctl_t                           ctl,
    input  logic [MAX_DIMS-1:0][ADDR_WIDTH-1:0]  strides,
    input  logic [ADDR_WIDTH-1:0]                start_addr,
    input  logic [STATUS_W-1:0]                  cfg_status,
    input  logic                                 q_avail,
    input  item_t                                q_head,
    output logic                                 q_pop,
    output logic                                 out_valid,
    input  logic                                 out_stall,
    output logic [OFFSET_W-1:0]                  dest_offset,
    output logic [DATA_W-1:0]                    out_data,
    output logic                                 last_elem,
    output logic [STATUS_W-1:0]                  status
);

    logic [ADDR_WIDTH-1:0]  base_reg [MAX_DIMS];
    logic [ADDR_WIDTH-1:0]  advanced;
    logic                   out_valid_reg;
    logic [OFFSET_W-1:0]    dest_offset_reg;
    logic [DATA_W-1:0]      out_data_reg;
    logic                   last_reg;
    logic [STATUS_W-1:0]    status_reg;

    assign q_pop    = q_avail && (!out_valid_reg || !out_stall);
    assign advanced = base_reg[q_head.level] + strides[q_head.level];

    // Walk the per-level base addresses; levels below the carry take its value.
    always_ff @(posedge clk)
    begin
        if (ctl.restart)
        begin
            for (int t = 0; t < MAX_DIMS; t++)
            begin
                base_reg[t] <= start_addr;
            end
        end
        else if (q_pop)
        begin
            for (int t = 0; t < MAX_DIMS; t++)
            begin
                if (q_head.last)
                begin
                    base_reg[t] <= start_addr;
                end
                else if (LEVEL_W'(t) <= q_head.level)
                begin
                    base_reg[t] <= advanced;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (q_pop)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (q_pop)
        begin
            dest_offset_reg <= (cfg_status != STATUS_OK) ? '0 : OFFSET_W'(base_reg[0]);
            out_data_reg    <= q_head.data;
            last_reg        <= q_head.last;
            status_reg      <= cfg_status;
        end
    end

    assign out_valid   = out_valid_reg;
    assign dest_offset = dest_offset_reg;
    assign out_data    = out_data_reg;
    assign last_elem   = last_reg;
    assign status      = status_reg;

endmodule

// ===== rtl/transposed_slab_copy_address_gen.sv =====
// Channel   Direction  Handshake                   Payload
// input     in         in_valid / in_stall         elem_data
// output    out        out_valid / out_stall       dest_offset, out_data, last_elem, status
// config    in         psel, penable, pwrite       paddr, pwdata, prdata, pready
//
// One item per cycle unless stalled; an accepted item passes through a four-entry
// queue and an output register, so either side may stall without the other stopping.
// Stride setup runs after reset and after each write to a configuration register,
// one dimension a cycle through the stride multipliers; in_stall stays high meanwhile.
// Reset is asynchronous, active low, and restores the default configuration.
`include "transposed_slab_copy_address_gen_defines.svh"

module transposed_slab_copy_address_gen import tsc_pkg::*; #(
    parameter int ADDR_WIDTH = 32
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_valid,
    output logic                   in_stall,
    input  logic [DATA_W-1:0]      elem_data,
    output logic                   out_valid,
    input  logic                   out_stall,
    output logic [OFFSET_W-1:0]    dest_offset,
    output logic [DATA_W-1:0]      out_data,
    output logic                   last_elem,
    output logic [STATUS_W-1:0]    status,
    input  logic                   psel,
    input  logic                   penable,
    input  logic                   pwrite,
    input  logic [CFG_ADDR_W-1:0]  paddr,
    input  logic [CFG_DATA_W-1:0]  pwdata,
    output logic [CFG_DATA_W-1:0]  prdata,
    output logic                   pready
);

    setup_ctl_t                           setup_ctl;
    dim_t [MAX_DIMS-1:0]                  len_m1;
    logic [MAX_DIMS-1:0][ADDR_WIDTH-1:0]  strides;
    logic [ADDR_WIDTH-1:0]                start_addr;
    logic [STATUS_W-1:0]                  cfg_status;
    logic                                 q_push;
    item_t                                q_item;
    logic                                 q_pop;
    item_t                                q_head;
    logic                                 q_full;
    logic                                 q_avail;

    assign pready = 1'b1;

    tsc_setup #(
        .ADDR_WIDTH (ADDR_WIDTH)
    ) u_setup (
        .clk        (clk),
        .rst_n      (rst_n),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .ctl        (setup_ctl),
        .len_m1     (len_m1),
        .strides    (strides),
        .start_addr (start_addr),
        .cfg_status (cfg_status)
    );

    tsc_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctl       (setup_ctl),
        .len_m1    (len_m1),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .elem_data (elem_data),
        .q_full    (q_full),
        .q_push    (q_push),
        .q_item    (q_item)
    );

    tsc_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_item (q_item),
        .pop       (q_pop),
        .head      (q_head),
        .full      (q_full),
        .avail     (q_avail)
    );

    tsc_back #(
        .ADDR_WIDTH (ADDR_WIDTH)
    ) u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .ctl         (setup_ctl),
        .strides     (strides),
        .start_addr  (start_addr),
        .cfg_status  (cfg_status),
        .q_avail     (q_avail),
        .q_head      (q_head),
        .q_pop       (q_pop),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .dest_offset (dest_offset),
        .out_data    (out_data),
        .last_elem   (last_elem),
        .status      (status)
    );

    `TSC_ASSERT_IMP(a_zero_offset_on_error, clk, rst_n, out_valid && (status != STATUS_OK), dest_offset == '0)
    `TSC_ASSERT_IMP(a_status_steady, clk, rst_n, !setup_ctl.busy && !$past(setup_ctl.busy), $stable(cfg_status))
    `TSC_ASSERT_IMP(a_result_from_queue, clk, rst_n, $rose(out_valid), $past(q_pop))

endmodule

// ===== verif/tb_transposed_slab_copy_address_gen.sv =====
module tb_transposed_slab_copy_address_gen;
    import tsc_pkg::*;

    localparam int ADDR_W = 32;

    typedef struct {
        logic [OFFSET_W-1:0] offset;
        logic [DATA_W-1:0]   data;
        logic                last;
        logic [STATUS_W-1:0] status;
    } dest_item_t;

    typedef struct {
        bit                   is_write;
        logic [REG_IDX_W-1:0] idx;
        logic [63:0]          value;
        bit                   typed;
        logic [OFFSET_W-1:0]  offset;
        logic                 last;
        logic [STATUS_W-1:0]  status;
    } stim_row_t;

    logic                  clk = 1'b0;
    logic                  rst_n;
    logic                  in_valid;
    logic                  in_stall;
    logic [DATA_W-1:0]     elem_data;
    logic                  out_valid;
    logic                  out_stall;
    logic [OFFSET_W-1:0]   dest_offset;
    logic [DATA_W-1:0]     out_data;
    logic                  last_elem;
    logic [STATUS_W-1:0]   status;
    logic                  psel;
    logic                  penable;
    logic                  pwrite;
    logic [CFG_ADDR_W-1:0] paddr;
    logic [CFG_DATA_W-1:0] pwdata;
    logic [CFG_DATA_W-1:0] prdata;
    logic                  pready;

    // shadow configuration
    logic [RANK_W-1:0]  cfg_rank;
    logic [ORDER_W-1:0] cfg_order;
    logic [63:0]        cfg_dest;
    logic [63:0]        cfg_slab;
    logic [63:0]        cfg_offs;
    logic [EB_W-1:0]    cfg_eb;

    // walk state derived from it
    int unsigned         seg_len [MAX_DIMS];
    int unsigned         walk_cnt [MAX_DIMS];
    logic [ADDR_W-1:0]   level_addr [MAX_DIMS];
    logic [ADDR_W-1:0]   stride_src [MAX_DIMS];
    logic [ADDR_W-1:0]   base_addr;
    logic [STATUS_W-1:0] err_code;

    dest_item_t awaited_items [$];
    dest_item_t monitor_want;
    stim_row_t  stim_rows [$];

    bit steady;
    int failures;
    int items_sent;
    int slab_wraps;
    int err_items;
    int cfg_phases;

    transposed_slab_copy_address_gen #(
        .ADDR_WIDTH(ADDR_W)
    ) u_dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .elem_data  (elem_data),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .dest_offset(dest_offset),
        .out_data   (out_data),
        .last_elem  (last_elem),
        .status     (status),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .pready     (pready)
    );

    always #5 clk = ~clk;

    function automatic void restart_walk();
        for (int n = 0; n < MAX_DIMS; n++)
        begin
            walk_cnt[n] = 0;
            level_addr[n] = base_addr;
        end
    endfunction

    function automatic void compute_strides();
        int                r;
        int                s;
        int unsigned       sl;
        int unsigned       dsel [MAX_DIMS];
        longint unsigned   dlen [MAX_DIMS];
        longint unsigned   off [MAX_DIMS];
        longint unsigned   stride [MAX_DIMS];
        longint unsigned   total;
        longint unsigned   lim;
        longint unsigned   prod;
        bit                misfit;
        bit                toolarge;
        r = cfg_rank > MAX_DIMS ? MAX_DIMS : cfg_rank;
        lim = 64'd1 << ADDR_W;
        total = cfg_eb == 0 ? 1 : (cfg_eb > EB_MAX ? EB_MAX : cfg_eb);
        stride[0] = total;
        misfit = 1'b0;
        toolarge = 1'b0;
        for (int n = 0; n < MAX_DIMS; n++)
        begin
            sl = n < r ? cfg_slab[n*DIM_WIDTH +: DIM_WIDTH] : 1;
            seg_len[n] = sl == 0 ? 1 : sl;
            off[n] = n < r ? cfg_offs[n*DIM_WIDTH +: DIM_WIDTH] : 0;
            dlen[n] = n < r ? cfg_dest[n*DIM_WIDTH +: DIM_WIDTH] : 1;
            dsel[n] = n < r ? cfg_order[2*n +: 2] : n;
        end
        for (int n = 0; n < MAX_DIMS; n++)
        begin
            s = dsel[n];
            if (n < r && off[s] + seg_len[s] > dlen[n])
                misfit = 1'b1;
            if (dlen[n] != 0 && total > lim / dlen[n])
                toolarge = 1'b1;
            if (dlen[n] == 0)
                total = 0;
            else if (!toolarge)
                total = total * dlen[n];
        end
        err_code = misfit ? STATUS_MISFIT : (toolarge ? STATUS_TOO_LARGE : STATUS_OK);
        for (int n = 1; n < MAX_DIMS; n++)
            stride[n] = (stride[n-1] * dlen[n-1]) & (lim - 1);
        base_addr = '0;
        for (int n = 0; n < MAX_DIMS; n++)
            stride_src[n] = '0;
        for (int n = 0; n < MAX_DIMS; n++)
        begin
            s = dsel[n];
            prod = stride[n] * off[s];
            stride_src[s] = stride_src[s] + stride[n][ADDR_W-1:0];
            base_addr = base_addr + prod[ADDR_W-1:0];
        end
        restart_walk();
    endfunction

    function automatic void apply_reg(logic [REG_IDX_W-1:0] idx, logic [63:0] v);
        case (idx)
            REG_RANK:         cfg_rank = v[RANK_W-1:0];
            REG_DIM_ORDER:    cfg_order = v[ORDER_W-1:0];
            REG_DEST_SIZES:   cfg_dest = v;
            REG_SLAB_SIZES:   cfg_slab = v;
            REG_SLAB_OFFSETS: cfg_offs = v;
            REG_ELEM_BYTES:   cfg_eb = v[EB_W-1:0];
            default:          return;
        endcase
        compute_strides();
    endfunction

    function automatic dest_item_t walk_next(logic [DATA_W-1:0] d);
        dest_item_t res;
        bit         at_end;
        bit         done;
        at_end = 1'b1;
        for (int n = 0; n < MAX_DIMS; n++)
            if (walk_cnt[n] != seg_len[n] - 1)
                at_end = 1'b0;
        res.offset = err_code != STATUS_OK ? '0 : level_addr[0];
        res.data = d;
        res.last = at_end;
        res.status = err_code;
        if (at_end)
        begin
            restart_walk();
        end
        else
        begin
            done = 1'b0;
            for (int n = 0; n < MAX_DIMS; n++)
            begin
                if (!done)
                begin
                    walk_cnt[n]++;
                    if (walk_cnt[n] < seg_len[n])
                    begin
                        level_addr[n] = level_addr[n] + stride_src[n];
                        for (int t = 0; t < n; t++)
                            level_addr[t] = level_addr[n];
                        done = 1'b1;
                    end
                    else
                    begin
                        walk_cnt[n] = 0;
                    end
                end
            end
        end
        return res;
    endfunction

    function automatic void add_write(logic [REG_IDX_W-1:0] idx, logic [63:0] v);
        stim_row_t row;
        row = '{default: '0};
        row.is_write = 1'b1;
        row.idx = idx;
        row.value = v;
        stim_rows.push_back(row);
    endfunction

    function automatic void add_elem(logic [63:0] d);
        stim_row_t row;
        row = '{default: '0};
        row.value = d;
        stim_rows.push_back(row);
    endfunction

    function automatic void add_known(logic [63:0] d, logic [OFFSET_W-1:0] off, logic lst,
                                      logic [STATUS_W-1:0] st);
        stim_row_t row;
        row = '{default: '0};
        row.value = d;
        row.typed = 1'b1;
        row.offset = off;
        row.last = lst;
        row.status = st;
        stim_rows.push_back(row);
    endfunction

    task automatic wait_drain();
        in_valid <= 1'b0;
        while (awaited_items.size() != 0)
            @(negedge clk);
        repeat (6) @(negedge clk);
    endtask

    task automatic write_reg(logic [REG_IDX_W-1:0] idx, logic [63:0] v);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {idx, {REG_LSB{1'b0}}};
        pwdata <= v;
        @(negedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        apply_reg(idx, v);
        @(negedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        @(negedge clk);
    endtask

    task automatic send_elem(logic [DATA_W-1:0] d, bit typed, dest_item_t fixed);
        dest_item_t pred;
        while (!steady && $urandom_range(0, 99) < 32)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid <= 1'b1;
        elem_data <= d;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        pred = walk_next(d);
        awaited_items.push_back(typed ? fixed : pred);
        items_sent++;
        if (pred.last)
            slab_wraps++;
        if (pred.status != STATUS_OK)
            err_items++;
        @(negedge clk);
    endtask

    always @(negedge clk)
    begin
        out_stall <= (!steady && $urandom_range(0, 99) < 32);
    end

    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
        begin
            if (awaited_items.size() == 0)
            begin
                $error("unexpected item: dest_offset %h out_data %h", dest_offset, out_data);
                failures++;
            end
            else
            begin
                monitor_want = awaited_items.pop_front();
                if (dest_offset !== monitor_want.offset)
                begin
                    $error("dest_offset expected %h actual %h", monitor_want.offset, dest_offset);
                    failures++;
                end
                if (out_data !== monitor_want.data)
                begin
                    $error("out_data expected %h actual %h", monitor_want.data, out_data);
                    failures++;
                end
                if (last_elem !== monitor_want.last)
                begin
                    $error("last_elem expected %b actual %b", monitor_want.last, last_elem);
                    failures++;
                end
                if (status !== monitor_want.status)
                begin
                    $error("status expected %0d actual %0d", monitor_want.status, status);
                    failures++;
                end
            end
        end
    end

    initial
    begin
        #3000000;
        $display("FAIL transposed_slab_copy_address_gen");
        $finish;
    end

    initial
    begin
        dest_item_t      fixed;
        logic [63:0]     v;
        logic [63:0]     slab_v;
        logic [63:0]     offs_v;
        logic [63:0]     dest_v;
        logic [7:0]      order_v;
        int unsigned     rank_v;
        int unsigned     eb_v;
        int unsigned     rc;
        int unsigned     k;
        int unsigned     f;
        int unsigned     s;
        int unsigned     need;
        int unsigned     tmp;
        int unsigned     j;
        int unsigned     perm [MAX_DIMS];
        int unsigned     lenn [MAX_DIMS];
        int unsigned     offn [MAX_DIMS];
        longint unsigned total;
        int              n_items;
        int              random_sent;

        rst_n = 1'b0;
        in_valid = 1'b0;
        elem_data = '0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        steady = 1'b0;
        failures = 0;
        items_sent = 0;
        slab_wraps = 0;
        err_items = 0;
        cfg_phases = 0;
        random_sent = 0;

        cfg_rank = 3'd1;
        cfg_order = 8'd228;
        cfg_dest = 64'h0001_0001_0001_0001;
        cfg_slab = 64'h0001_0001_0001_0001;
        cfg_offs = 64'h0;
        cfg_eb = 4'd4;
        compute_strides();

        repeat (2) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        add_known(64'h0, '0, 1'b1, STATUS_OK);
        add_known('1, '0, 1'b1, STATUS_OK);
        add_write(REG_RANK, 64'd0);
        add_known(64'h5555_5555_5555_5555, '0, 1'b1, STATUS_OK);
        add_write(REG_RANK, 64'd7);
        add_known(64'hAAAA_AAAA_AAAA_AAAA, '0, 1'b1, STATUS_OK);
        add_write(REG_RANK, 64'd1);
        add_write(REG_SLAB_OFFSETS, 64'h0000_0000_0000_0001);
        add_known(64'h0123_4567_89AB_CDEF, '0, 1'b1, STATUS_MISFIT);
        add_write(REG_RANK, 64'd2);
        add_write(REG_DEST_SIZES, 64'h0001_0001_FFFF_FFFF);
        add_write(REG_SLAB_OFFSETS, 64'h0);
        add_known(64'hFEDC_BA98_7654_3210, '0, 1'b1, STATUS_TOO_LARGE);
        add_write(REG_SLAB_OFFSETS, 64'h0000_0000_0000_FFFF);
        add_known(64'h8000_0000_0000_0001, '0, 1'b1, STATUS_MISFIT);
        add_write(REG_SLAB_OFFSETS, 64'h0000_0000_0001_0002);
        add_write(REG_DEST_SIZES, 64'h0001_0001_0004_0005);
        add_write(REG_SLAB_SIZES, 64'h0001_0001_0003_0002);
        add_write(REG_DIM_ORDER, 64'hE1);
        add_write(REG_ELEM_BYTES, 64'd0);
        for (int i = 0; i < 7; i++)
            add_elem({$urandom, $urandom});
        add_write(REG_ELEM_BYTES, 64'd15);
        for (int i = 0; i < 3; i++)
            add_elem({$urandom, $urandom});
        add_write(REG_DIM_ORDER, 64'hE0);
        add_elem({$urandom, $urandom});
        add_elem({$urandom, $urandom});
        add_write(REG_DIM_ORDER, 64'hEC);
        add_elem({$urandom, $urandom});
        add_elem({$urandom, $urandom});
        add_write(REG_SLAB_SIZES, 64'h0);
        add_elem({$urandom, $urandom});
        add_elem({$urandom, $urandom});

        foreach (stim_rows[i])
        begin
            if (stim_rows[i].is_write)
            begin
                wait_drain();
                write_reg(stim_rows[i].idx, stim_rows[i].value);
            end
            else
            begin
                fixed.offset = stim_rows[i].offset;
                fixed.data = stim_rows[i].value;
                fixed.last = stim_rows[i].last;
                fixed.status = stim_rows[i].status;
                send_elem(stim_rows[i].value, stim_rows[i].typed, fixed);
            end
        end

        while (random_sent < 1150)
        begin
            wait_drain();
            cfg_phases++;

            rank_v = $urandom_range(0, 9) < 8 ? $urandom_range(1, 4) : $urandom_range(0, 7);
            rc = rank_v > MAX_DIMS ? MAX_DIMS : rank_v;
            for (int n = 0; n < MAX_DIMS; n++)
                perm[n] = n;
            for (int n = MAX_DIMS - 1; n > 0; n--)
            begin
                j = $urandom_range(0, n);
                tmp = perm[n];
                perm[n] = perm[j];
                perm[j] = tmp;
            end
            if ($urandom_range(0, 9) < 7)
                order_v = {perm[3][1:0], perm[2][1:0], perm[1][1:0], perm[0][1:0]};
            else
                order_v = 8'($urandom_range(0, 255));

            for (int n = 0; n < MAX_DIMS; n++)
            begin
                k = $urandom_range(0, 99);
                if (k < 70)
                    f = $urandom_range(1, 4);
                else if (k < 80)
                    f = 0;
                else if (k < 97)
                    f = $urandom_range(5, 8);
                else
                    f = $urandom_range(0, 65535);
                slab_v[n*DIM_WIDTH +: DIM_WIDTH] = DIM_WIDTH'(f);
                lenn[n] = n < rc ? (f == 0 ? 1 : f) : 1;
                k = $urandom_range(0, 99);
                if (k < 80)
                    f = $urandom_range(0, 3);
                else if (k < 90)
                    f = $urandom_range(0, 65535);
                else
                    f = 16'hFFFF;
                offs_v[n*DIM_WIDTH +: DIM_WIDTH] = DIM_WIDTH'(f);
                offn[n] = n < rc ? f : 0;
            end
            for (int n = 0; n < MAX_DIMS; n++)
            begin
                s = order_v[2*n +: 2];
                need = s < rc ? offn[s] + lenn[s] : 1;
                k = $urandom_range(0, 99);
                if (k < 75)
                    f = need + $urandom_range(0, 3);
                else if (k < 85)
                    f = $urandom_range(0, 65535);
                else if (k < 90)
                    f = 0;
                else if (k < 95)
                    f = 16'hFFFF;
                else
                    f = $urandom_range(0, 8);
                dest_v[n*DIM_WIDTH +: DIM_WIDTH] = DIM_WIDTH'(f > 65535 ? 65535 : f);
            end
            if ($urandom_range(0, 9) < 8)
                eb_v = $urandom_range(1, EB_MAX);
            else
                eb_v = $urandom_range(0, 7) == 0 ? 0 : $urandom_range(EB_MAX + 1, 15);

            v = $urandom_range(0, 7) == 0 ? {$urandom, $urandom} : 64'h0;
            v[RANK_W-1:0] = RANK_W'(rank_v);
            write_reg(REG_RANK, v);
            v = $urandom_range(0, 7) == 0 ? {$urandom, $urandom} : 64'h0;
            v[ORDER_W-1:0] = order_v;
            write_reg(REG_DIM_ORDER, v);
            write_reg(REG_SLAB_SIZES, slab_v);
            write_reg(REG_SLAB_OFFSETS, offs_v);
            write_reg(REG_DEST_SIZES, dest_v);
            v = $urandom_range(0, 7) == 0 ? {$urandom, $urandom} : 64'h0;
            v[EB_W-1:0] = EB_W'(eb_v);
            write_reg(REG_ELEM_BYTES, v);

            total = 1;
            for (int n = 0; n < MAX_DIMS; n++)
                total = total * seg_len[n];
            if (total <= 160)
                n_items = int'(total) * $urandom_range(1, 2) + $urandom_range(0, 2);
            else
                n_items = $urandom_range(16, 64);

            for (int i = 0; i < n_items && random_sent < 1150; i++)
            begin
                steady = random_sent >= 300 && random_sent < 450;
                if (random_sent == 600)
                    wait_drain();
                send_elem({$urandom, $urandom}, 1'b0, fixed);
                random_sent++;
            end
        end

        steady = 1'b0;
        wait_drain();
        repeat (8) @(negedge clk);

        $display("Run covered %0d items over %0d random configurations plus directed cases,",
                 items_sent, cfg_phases);
        $display("with %0d slab wraps and %0d items under an error status.",
                 slab_wraps, err_items);
        if (failures == 0)
            $display("PASS transposed_slab_copy_address_gen");
        else
            $display("FAIL transposed_slab_copy_address_gen");
        $finish;
    end

endmodule
